>>> rtl/ecder_pkg.sv
// Shared constants, codes and types for the ECDSA raw-to-DER encoder.
// Used by ecder_byte_sel and ecdsa_raw_to_der_encoder_top; depends on nothing.
package ecder_pkg;

    // Raw buffer sizing.
    localparam int MAX_RAW_BYTES = 132;
    localparam int ADDR_W        = $clog2(MAX_RAW_BYTES);
    localparam int CNT_W         = $clog2(MAX_RAW_BYTES + 2);
    localparam int HALF_W        = $clog2(MAX_RAW_BYTES / 2 + 1);

    // DER positions and lengths follow the 9-bit der_length field.
    localparam int POS_W = 9;

    // Request codes.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // DER tags and length-form markers.
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LEN_LONG_1   = 8'h81;
    localparam logic [7:0] LEN_LONG_2   = 8'h82;
    localparam logic [7:0] TOP_BIT      = 8'h80;
    localparam logic [7:0] BYTE_MAX     = 8'hff;

    // Encoding layout captured at the end of a load.
    typedef struct packed {
        logic [HALF_W-1:0] half;
        logic [HALF_W-1:0] r_skip;
        logic [HALF_W-1:0] s_skip;
        logic              r_pad;
        logic              s_pad;
        logic [POS_W-1:0]  body;
        logic [1:0]        head_len;
    } layout_t;

    // Selection for one DER byte: a constant value or a buffer read.
    typedef struct packed {
        logic              use_mem;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        value;
    } byte_sel_t;

endpackage

>>> rtl/ecdsa_raw_to_der_encoder_top.sv
// Top level of the ECDSA raw-to-DER encoder: raw buffer memory, scan and pull sequencer.
// Depends on ecder_pkg and instantiates ecder_byte_sel.

// Raw r||s bytes are pushed one per beat into a 132-byte buffer held in a
// synchronous memory; a push that is not last gives no result. The push
// marked last gives either a registered error beat (odd length or overflow),
// or, after a scan of the buffer, a summary beat with the total DER length.
// The scan reads the memory one byte at a time (issue, then check the
// registered data) for the leading zeros of r and then of s. Each pull
// reads its DER byte through the registered read port and gives it as a
// registered byte beat; a pull with nothing pending answers with a none
// beat from the idle state. A push during a pending encoding abandons it
// and starts a new load.
module ecdsa_raw_to_der_encoder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [7:0]                    raw_byte,
    input  logic                          raw_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [7:0]                    out_byte,
    output logic [ecder_pkg::POS_W-1:0]   der_length,
    output logic                          out_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CK   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_PULL = 3'd4;

    localparam int ADDR_W = ecder_pkg::ADDR_W;
    localparam int CNT_W  = ecder_pkg::CNT_W;
    localparam int HALF_W = ecder_pkg::HALF_W;
    localparam int POS_W  = ecder_pkg::POS_W;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rdy_reg, rdy_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [HALF_W-1:0] half_reg, half_next;
    logic [HALF_W-1:0] r_skip_reg, r_skip_next;
    logic [HALF_W-1:0] s_skip_reg, s_skip_next;
    logic              r_pad_reg, r_pad_next;
    logic              s_pad_reg, s_pad_next;
    logic [POS_W-1:0]  body_reg, body_next;
    logic [1:0]        head_len_reg, head_len_next;
    logic [POS_W-1:0]  total_reg, total_next;
    logic [HALF_W-1:0] k_reg, k_next;
    logic              phase_reg, phase_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic [POS_W-1:0]  der_length_reg, der_length_next;
    logic              out_last_reg, out_last_next;

    logic [7:0]        raw_mem [ecder_pkg::MAX_RAW_BYTES];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              we;

    logic [CNT_W-1:0]  cnt_base;
    logic [CNT_W-1:0]  cnt_new;
    logic [CNT_W-1:0]  scan_addr;
    logic [POS_W-1:0]  fin_rsz;
    logic [POS_W-1:0]  fin_ssz;
    logic [POS_W-1:0]  fin_body;
    logic [1:0]        fin_hl;

    ecder_pkg::layout_t   lay;
    ecder_pkg::byte_sel_t sel;

    // Layout of the pending encoding feeds the byte selector.
    always_comb
    begin
        lay.half     = half_reg;
        lay.r_skip   = r_skip_reg;
        lay.s_skip   = s_skip_reg;
        lay.r_pad    = r_pad_reg;
        lay.s_pad    = s_pad_reg;
        lay.body     = body_reg;
        lay.head_len = head_len_reg;
    end

    ecder_byte_sel u_byte_sel (
        .lay (lay),
        .pos (pos_reg),
        .sel (sel)
    );

    // Raw buffer memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            raw_mem[wr_addr] <= raw_byte;
        end
        rd_data_reg <= raw_mem[rd_addr];
    end

    // A push into a pending encoding restarts the load at the first entry.
    assign cnt_base  = rdy_reg ? '0 : count_reg;
    assign wr_addr   = cnt_base[ADDR_W-1:0];
    assign scan_addr = (phase_reg ? CNT_W'(half_reg) : '0) + CNT_W'(k_reg);

    // Integer and sequence sizes once both skips are known.
    always_comb
    begin
        fin_rsz  = POS_W'(2) + POS_W'(r_pad_reg) + POS_W'(half_reg) - POS_W'(r_skip_reg);
        fin_ssz  = POS_W'(2) + POS_W'(s_pad_reg) + POS_W'(half_reg) - POS_W'(s_skip_reg);
        fin_body = fin_rsz + fin_ssz;
        if (fin_body < POS_W'(ecder_pkg::TOP_BIT))
        begin
            fin_hl = 2'd1;
        end
        else if (fin_body <= POS_W'(ecder_pkg::BYTE_MAX))
        begin
            fin_hl = 2'd2;
        end
        else
        begin
            fin_hl = 2'd3;
        end
    end

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);

    // Sequencer: load, scan for leading zeros, summarize, and serve pulls.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rdy_next        = rdy_reg;
        pos_next        = pos_reg;
        half_next       = half_reg;
        r_skip_next     = r_skip_reg;
        s_skip_next     = s_skip_reg;
        r_pad_next      = r_pad_reg;
        s_pad_next      = s_pad_reg;
        body_next       = body_reg;
        head_len_next   = head_len_reg;
        total_next      = total_reg;
        k_next          = k_reg;
        phase_next      = phase_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        out_byte_next   = out_byte_reg;
        der_length_next = der_length_reg;
        out_last_next   = out_last_reg;
        we              = 1'b0;
        rd_addr         = sel.addr;
        cnt_new         = cnt_base;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (req_type == ecder_pkg::REQ_PUSH)
                    begin
                        rdy_next = 1'b0;
                        pos_next = '0;
                        if (cnt_base < CNT_W'(ecder_pkg::MAX_RAW_BYTES))
                        begin
                            we      = 1'b1;
                            cnt_new = cnt_base + CNT_W'(1);
                        end
                        else
                        begin
                            cnt_new = CNT_W'(ecder_pkg::MAX_RAW_BYTES + 1);
                        end
                        count_next = cnt_new;
                        if (raw_last)
                        begin
                            if ((cnt_new > CNT_W'(ecder_pkg::MAX_RAW_BYTES)) || cnt_new[0])
                            begin
                                count_next      = '0;
                                out_valid_next  = 1'b1;
                                kind_next       = ecder_pkg::KIND_ERROR;
                                out_byte_next   = 8'h00;
                                der_length_next = '0;
                                out_last_next   = 1'b0;
                            end
                            else
                            begin
                                half_next  = HALF_W'(cnt_new[CNT_W-1:1]);
                                k_next     = '0;
                                phase_next = 1'b0;
                                state_next = S_RD;
                            end
                        end
                    end
                    else if (!rdy_reg)
                    begin
                        out_valid_next  = 1'b1;
                        kind_next       = ecder_pkg::KIND_NONE;
                        out_byte_next   = 8'h00;
                        der_length_next = '0;
                        out_last_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = S_PULL;
                    end
                end
            end

            S_RD:
            begin
                rd_addr    = scan_addr[ADDR_W-1:0];
                state_next = S_CK;
            end

            S_CK:
            begin
                if ((rd_data_reg == 8'h00) && ((k_reg + HALF_W'(1)) < half_reg))
                begin
                    k_next     = k_reg + HALF_W'(1);
                    state_next = S_RD;
                end
                else if (!phase_reg)
                begin
                    r_skip_next = k_reg;
                    r_pad_next  = rd_data_reg[7];
                    phase_next  = 1'b1;
                    k_next      = '0;
                    state_next  = S_RD;
                end
                else
                begin
                    s_skip_next = k_reg;
                    s_pad_next  = rd_data_reg[7];
                    state_next  = S_FIN;
                end
            end

            S_FIN:
            begin
                body_next       = fin_body;
                head_len_next   = fin_hl;
                total_next      = POS_W'(1) + POS_W'(fin_hl) + fin_body;
                pos_next        = '0;
                rdy_next        = 1'b1;
                out_valid_next  = 1'b1;
                kind_next       = ecder_pkg::KIND_SUMMARY;
                out_byte_next   = 8'h00;
                der_length_next = POS_W'(1) + POS_W'(fin_hl) + fin_body;
                out_last_next   = 1'b0;
                state_next      = S_IDLE;
            end

            S_PULL:
            begin
                out_valid_next  = 1'b1;
                kind_next       = ecder_pkg::KIND_BYTE;
                out_byte_next   = sel.use_mem ? rd_data_reg : sel.value;
                der_length_next = '0;
                if ((pos_reg + POS_W'(1)) >= total_reg)
                begin
                    out_last_next = 1'b1;
                    rdy_next      = 1'b0;
                    count_next    = '0;
                    pos_next      = '0;
                end
                else
                begin
                    out_last_next = 1'b0;
                    pos_next      = pos_reg + POS_W'(1);
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rdy_reg       <= 1'b0;
            pos_reg       <= '0;
            half_reg      <= '0;
            r_skip_reg    <= '0;
            s_skip_reg    <= '0;
            r_pad_reg     <= 1'b0;
            s_pad_reg     <= 1'b0;
            body_reg      <= '0;
            head_len_reg  <= 2'd1;
            total_reg     <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rdy_reg       <= rdy_next;
            pos_reg       <= pos_next;
            half_reg      <= half_next;
            r_skip_reg    <= r_skip_next;
            s_skip_reg    <= s_skip_next;
            r_pad_reg     <= r_pad_next;
            s_pad_reg     <= s_pad_next;
            body_reg      <= body_next;
            head_len_reg  <= head_len_next;
            total_reg     <= total_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output beat payload.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        out_byte_reg   <= out_byte_next;
        der_length_reg <= der_length_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign out_byte   = out_byte_reg;
    assign der_length = der_length_reg;
    assign out_last   = out_last_reg;

endmodule

>>> rtl/ecder_byte_sel.sv
// DER byte selector: maps an output position to a header or pad byte or a buffer address.
// Depends on ecder_pkg for the layout and selection types.
module ecder_byte_sel (
    input  ecder_pkg::layout_t   lay,
    input  logic [ecder_pkg::POS_W-1:0] pos,
    output ecder_pkg::byte_sel_t sel
);

    logic [ecder_pkg::POS_W-1:0] hl;
    logic [ecder_pkg::POS_W-1:0] rsz;
    logic [ecder_pkg::POS_W-1:0] q;
    logic [ecder_pkg::POS_W-1:0] qi;
    logic [ecder_pkg::POS_W-1:0] base;
    logic [ecder_pkg::POS_W-1:0] skip;
    logic                        pad;
    logic [ecder_pkg::POS_W-1:0] ilen;
    logic [ecder_pkg::POS_W-1:0] mem_idx;

    // Split the position into sequence header, r integer and s integer.
    always_comb
    begin
        hl  = ecder_pkg::POS_W'(lay.head_len);
        rsz = ecder_pkg::POS_W'(2) + ecder_pkg::POS_W'(lay.r_pad)
            + ecder_pkg::POS_W'(lay.half) - ecder_pkg::POS_W'(lay.r_skip);
        q   = pos - ecder_pkg::POS_W'(1) - hl;
        if (q < rsz)
        begin
            qi   = q;
            base = '0;
            skip = ecder_pkg::POS_W'(lay.r_skip);
            pad  = lay.r_pad;
        end
        else
        begin
            qi   = q - rsz;
            base = ecder_pkg::POS_W'(lay.half);
            skip = ecder_pkg::POS_W'(lay.s_skip);
            pad  = lay.s_pad;
        end
        ilen    = ecder_pkg::POS_W'(lay.half) - skip + ecder_pkg::POS_W'(pad);
        mem_idx = base + skip + qi - ecder_pkg::POS_W'(2) - ecder_pkg::POS_W'(pad);
    end

    // Pick the byte value, or point at the stored raw byte.
    always_comb
    begin
        sel.use_mem = 1'b0;
        sel.addr    = mem_idx[ecder_pkg::ADDR_W-1:0];
        sel.value   = 8'h00;
        if (pos == '0)
        begin
            sel.value = ecder_pkg::TAG_SEQUENCE;
        end
        else if (pos <= hl)
        begin
            case (lay.head_len)
                2'd1:
                begin
                    sel.value = lay.body[7:0];
                end
                2'd2:
                begin
                    sel.value = (pos == ecder_pkg::POS_W'(1)) ? ecder_pkg::LEN_LONG_1
                                                              : lay.body[7:0];
                end
                default:
                begin
                    if (pos == ecder_pkg::POS_W'(1))
                    begin
                        sel.value = ecder_pkg::LEN_LONG_2;
                    end
                    else if (pos == ecder_pkg::POS_W'(2))
                    begin
                        sel.value = {7'b0, lay.body[8]};
                    end
                    else
                    begin
                        sel.value = lay.body[7:0];
                    end
                end
            endcase
        end
        else if (qi == '0)
        begin
            sel.value = ecder_pkg::TAG_INTEGER;
        end
        else if (qi == ecder_pkg::POS_W'(1))
        begin
            sel.value = ilen[7:0];
        end
        else if (pad && (qi == ecder_pkg::POS_W'(2)))
        begin
            sel.value = 8'h00;
        end
        else
        begin
            sel.use_mem = 1'b1;
        end
    end

endmodule
